FILE: rtl/core/skts_pkg.sv
// ----------------------------------------------------------------------------
// skts_pkg: shared types and constants for the sorted key table
// Key widths, result field widths, operation codes and compare result type.
// ----------------------------------------------------------------------------
package skts_pkg;

   localparam int unsigned WORD_W      = 64;
   localparam int unsigned KEY_W       = 2 * WORD_W;
   localparam int unsigned OUT_IDX_W   = 13;
   localparam int unsigned DEF_CAPACITY = 4096;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   // outcome of one entry-versus-key compare
   typedef struct packed {
      logic below;   // entry < key
      logic equal;   // entry == key
   } cmp_result_type;

endpackage

FILE: rtl/core/skts_key_cmp.sv
// ----------------------------------------------------------------------------
// skts_key_cmp: 128-bit key compare
// Orders an entry against the search key, high word first, then low word.
// ----------------------------------------------------------------------------
module skts_key_cmp (
   input  logic [skts_pkg::WORD_W-1:0] entry_hi,
   input  logic [skts_pkg::WORD_W-1:0] entry_lo,
   input  logic [skts_pkg::WORD_W-1:0] key_hi,
   input  logic [skts_pkg::WORD_W-1:0] key_lo,
   output skts_pkg::cmp_result_type    result
);

   always_comb begin
      if (entry_hi != key_hi) begin
         result.below = entry_hi < key_hi;
         result.equal = 1'b0;
      end else begin
         result.below = entry_lo < key_lo;
         result.equal = entry_lo == key_lo;
      end
   end

endmodule

FILE: rtl/core/skts_key_ram.sv
// ----------------------------------------------------------------------------
// skts_key_ram: key storage
// One write port and one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module skts_key_ram #(
   parameter int unsigned CAPACITY = skts_pkg::DEF_CAPACITY,
   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [IW-1:0]              rd_addr,
   output logic [skts_pkg::KEY_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [IW-1:0]              wr_addr,
   input  logic [skts_pkg::KEY_W-1:0] wr_data
);

   logic [skts_pkg::KEY_W-1:0] mem [CAPACITY];
   logic [skts_pkg::KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sorted_key_table_search_insert.sv
// ----------------------------------------------------------------------------
// sorted_key_table_search_insert: sorted 128-bit key table, lookup and insert
// Keeps unique keys in ascending order in one RAM and searches it by
// lower-bound binary search; inserts shift the upper part of the table up.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one word per operation: tuser = func (0 lookup,
//   1 insert), tdata = key. rsp_ channel returns exactly one word per request
//   with found, position or insertion point, inserted, table_full and the
//   entry count after the operation.
//   The block works on one request at a time; req_tready is high only while
//   the sequencer is idle. A binary search step is a RAM read, then a compare
//   in the compare unit; a lookup runs at most S = ceil(log2(count+1)) steps.
//   An insert of a new key then moves every entry at or above the insertion
//   point up one slot, one RAM read and one RAM write per entry over the
//   single port pair, and writes the new key into the opened slot.
//   A new request is taken only after the result of the last one is loaded
//   into the output register and the sequencer is back in idle.
//   The result sits in an output register: a new request is taken while it
//   waits, and only the hand-off of the next result stalls on rsp_tready.
//   Reset empties the table (count cleared); RAM contents are not cleared,
//   entries at or above the count are never read.
// ----------------------------------------------------------------------------
module sorted_key_table_search_insert #(
   parameter int unsigned CAPACITY = skts_pkg::DEF_CAPACITY
) (
   input  logic         clock,
   input  logic         reset,
   // request: tuser = func; tdata = key_hi [63:0], key_lo [127:64]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic [0:0]   req_tuser,
   // response: tdata = found [0], match_index [13:1], inserted [14],
   // table_full [15], entry_count [28:16], zero [31:29]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata
);

   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned OW = skts_pkg::OUT_IDX_W;
   localparam int unsigned WW = skts_pkg::WORD_W;
   localparam int unsigned KW = skts_pkg::KEY_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SRCH_RD  = 3'd1;
   localparam logic [2:0] ST_SRCH_CMP = 3'd2;
   localparam logic [2:0] ST_SHIFT_RD = 3'd3;
   localparam logic [2:0] ST_SHIFT_WR = 3'd4;
   localparam logic [2:0] ST_DONE     = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // working registers of the current word
   logic          func_ff, func_in;
   logic [WW-1:0] key_hi_ff, key_hi_in;
   logic [WW-1:0] key_lo_ff, key_lo_in;
   logic [CW-1:0] left_ff, left_in;
   logic [CW-1:0] right_ff, right_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          found_ff, found_in;
   logic          inserted_ff, inserted_in;
   logic          full_ff, full_in;

   // output register
   logic [31:0]   rsp_data_ff, rsp_data_in;

   // RAM and compare hookup
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [KW-1:0] rd_data;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [KW-1:0] wr_data;
   skts_pkg::cmp_result_type cmp;

   logic [CW-1:0]    mid_calc;
   logic [CW-1:0]    idx_dec;
   logic [CW+OW-1:0] pos_ext;
   logic [CW+OW-1:0] cnt_ext;

   skts_key_ram #(
      .CAPACITY (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // entry word layout matches the request: hi in the low half
   skts_key_cmp u_cmp (
      .entry_hi (rd_data[WW-1:0]),
      .entry_lo (rd_data[KW-1:WW]),
      .key_hi   (key_hi_ff),
      .key_lo   (key_lo_ff),
      .result   (cmp)
   );

   assign mid_calc = left_ff + ((right_ff - left_ff) >> 1);
   assign idx_dec  = idx_ff - CW'(1);
   // zero-extended position and count; the response takes their low 13 bits
   assign pos_ext  = {{OW{1'b0}}, left_ff};
   assign cnt_ext  = {{OW{1'b0}}, count_ff};

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      func_in      = func_ff;
      key_hi_in    = key_hi_ff;
      key_lo_in    = key_lo_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      mid_in       = mid_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      inserted_in  = inserted_ff;
      full_in      = full_ff;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = mid_calc[IW-1:0];
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IW-1:0];
      wr_data      = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in     = req_tuser[0];
               key_hi_in   = req_tdata[WW-1:0];
               key_lo_in   = req_tdata[KW-1:WW];
               left_in     = '0;
               right_in    = count_ff;
               found_in    = 1'b0;
               inserted_in = 1'b0;
               full_in     = 1'b0;
               state_in    = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            if (left_ff < right_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid_calc[IW-1:0];
               mid_in   = mid_calc;
               state_in = ST_SRCH_CMP;
            end else if (func_ff == skts_pkg::FUNC_INSERT && !found_ff) begin
               if (count_ff >= CW'(CAPACITY)) begin
                  full_in  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  idx_in   = count_ff;
                  state_in = ST_SHIFT_RD;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SRCH_CMP: begin
            // keys are unique: an equal entry is the lower bound itself
            if (cmp.below) begin
               left_in = mid_ff + CW'(1);
            end else begin
               right_in = mid_ff;
            end
            found_in = found_ff | cmp.equal;
            state_in = ST_SRCH_RD;
         end
         ST_SHIFT_RD: begin
            if (idx_ff == left_ff) begin
               wr_en       = 1'b1;
               wr_data     = {key_lo_ff, key_hi_ff};
               count_in    = count_ff + CW'(1);
               inserted_in = 1'b1;
               state_in    = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_dec[IW-1:0];
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            // move entry idx-1 up to idx
            wr_en    = 1'b1;
            wr_data  = rd_data;
            idx_in   = idx_dec;
            state_in = ST_SHIFT_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {3'b000, cnt_ext[OW-1:0], full_ff, inserted_ff,
                               pos_ext[OW-1:0], found_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      key_hi_ff   <= key_hi_in;
      key_lo_ff   <= key_lo_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      mid_ff      <= mid_in;
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      inserted_ff <= inserted_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream-level check of the sorted key table
// A shadow copy of the table predicts each response word. The stimulus runs a
// directed pass over the corner keys, then random lookups and inserts.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WORD_W      = skts_pkg::WORD_W;
   localparam int unsigned KEY_W       = skts_pkg::KEY_W;
   localparam int unsigned OUT_IDX_W   = skts_pkg::OUT_IDX_W;
   localparam int unsigned CLK_PERIOD  = 8;
   localparam int unsigned TABLE_DEPTH = skts_pkg::DEF_CAPACITY;
   localparam int unsigned RANDOM_OPS  = 1030;
   localparam int unsigned HOLD_CYCLES = 300;   // long response back-pressure
   localparam int unsigned HOLD_AFTER  = 200;   // results seen before the hold
   localparam int unsigned DRAIN_WAIT  = 64;    // beyond the worst lookup latency
   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   // one request word as the sender sees it
   typedef struct {
      bit                wait_idle;   // hold off until all responses are in
      logic              func;
      logic [WORD_W-1:0] key_hi;
      logic [WORD_W-1:0] key_lo;
   } table_op_type;

   // one response word, unpacked
   typedef struct {
      bit                 found;
      bit [OUT_IDX_W-1:0] match_index;
      bit                 inserted;
      bit                 table_full;
      bit [OUT_IDX_W-1:0] entry_count;
   } table_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;    // key_hi [63:0], key_lo [127:64]
   logic [0:0]   req_tuser = '0;    // func [0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;         // found [0], match_index [13:1],
                                    // inserted [14], table_full [15],
                                    // entry_count [28:16], zero [31:29]

   table_op_type     pending_ops[$];
   table_result_type expected_results[$];

   // shadow table: keys as {hi, lo}, so one 128-bit compare orders them
   logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
   int unsigned      shadow_count = 0;

   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned words_sent = 0;
   int unsigned gap_left = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   logic        req_taken = 1'b0;

   sorted_key_table_search_insert #(.CAPACITY(TABLE_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int unsigned draw_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 98) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   // lower-bound search on the shadow table, then insert if asked
   function automatic table_result_type search_insert(logic func,
                                                      logic [WORD_W-1:0] hi,
                                                      logic [WORD_W-1:0] lo);
      table_result_type res;
      logic [KEY_W-1:0] key;
      int unsigned      left, right, mid, pos, i;
      key   = {hi, lo};
      left  = 0;
      right = shadow_count;
      while (left < right) begin
         mid = left + (right - left) / 2;
         if (shadow_keys[mid] < key) left = mid + 1;
         else right = mid;
      end
      pos = left;
      res.found       = (pos < shadow_count) && (shadow_keys[pos] == key);
      res.match_index = OUT_IDX_W'(pos);
      res.inserted    = 1'b0;
      res.table_full  = 1'b0;
      if (func == skts_pkg::FUNC_INSERT && !res.found) begin
         if (shadow_count >= TABLE_DEPTH) begin
            res.table_full = 1'b1;
         end else begin
            // open a slot at pos by moving the upper part up one
            for (i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i - 1];
            shadow_keys[pos] = key;
            shadow_count++;
            res.inserted = 1'b1;
         end
      end
      res.entry_count = OUT_IDX_W'(shadow_count);
      return res;
   endfunction

   task automatic queue_op(bit wait_idle, logic func, logic [KEY_W-1:0] key);
      table_op_type op;
      op.wait_idle = wait_idle;
      op.func      = func;
      op.key_hi    = key[KEY_W-1:WORD_W];
      op.key_lo    = key[WORD_W-1:0];
      pending_ops.insert(pending_ops.size(), op);
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Monitor: sample both handshakes at the rising edge. The response is
   // checked before the new request is predicted; a response cannot belong
   // to a request taken at the same edge.
   always @(posedge clock) begin
      table_result_type want;
      table_result_type pred;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready === 1'b1;
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("found", 16'(want.found), 16'(rsp_tdata[0]));
               check_field("match_index", 16'(want.match_index), 16'(rsp_tdata[13:1]));
               check_field("inserted", 16'(want.inserted), 16'(rsp_tdata[14]));
               check_field("table_full", 16'(want.table_full), 16'(rsp_tdata[15]));
               check_field("entry_count", 16'(want.entry_count), 16'(rsp_tdata[28:16]));
               check_field("pad", 16'd0, 16'(rsp_tdata[31:29]));
            end
         end
         if (req_tvalid && req_tready === 1'b1) begin
            pred = search_insert(req_tuser[0], req_tdata[63:0], req_tdata[127:64]);
            expected_results.insert(expected_results.size(), pred);
         end
      end
   end

   // Driver: changes the request at the falling edge. A word stays up until
   // taken; the gap after it is drawn when it is put up. Every fourth block
   // of 128 words runs with no gaps at all.
   always @(negedge clock) begin
      table_op_type op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // still waiting for req_tready
      end else if (gap_left != 0) begin
         req_tvalid <= 1'b0;
         gap_left--;
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].wait_idle && expected_results.size() != 0)) begin
         op = pending_ops.pop_front();
         req_tuser  <= op.func;
         req_tdata  <= {op.key_lo, op.key_hi};
         req_tvalid <= 1'b1;
         gap_left = ((words_sent / 128) % 4 == 2) ? 0 : draw_gap();
         words_sent++;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver: random stalls, calm stretches, and one long hold-off so that
   // the output register fills and req_tready drops while words keep coming.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if ((results_seen / 100) % 4 != 1 && $urandom_range(99) < 20) begin
         rsp_tready <= 1'b0;
         hold_left = draw_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] issued[$];
      logic             func;
      int unsigned      i, r;

      // directed: empty table, ordering on hi then lo, duplicates, extremes
      queue_op(1'b0, skts_pkg::FUNC_LOOKUP, {64'd0, 64'd0});
      queue_op(1'b0, skts_pkg::FUNC_LOOKUP, {ALL_ONES, ALL_ONES});
      queue_op(1'b0, skts_pkg::FUNC_INSERT, {64'd5, 64'd5});
      queue_op(1'b0, skts_pkg::FUNC_INSERT, {64'd5, 64'd5});     // already present
      queue_op(1'b0, skts_pkg::FUNC_INSERT, {64'd5, 64'd4});     // lo decides
      queue_op(1'b0, skts_pkg::FUNC_INSERT, {64'd5, 64'd6});
      queue_op(1'b0, skts_pkg::FUNC_INSERT, {64'd4, ALL_ONES});  // hi decides over lo
      queue_op(1'b0, skts_pkg::FUNC_INSERT, {64'd6, 64'd0});
      queue_op(1'b0, skts_pkg::FUNC_INSERT, {64'd0, 64'd0});
      queue_op(1'b0, skts_pkg::FUNC_INSERT, {ALL_ONES, 64'd0});
      queue_op(1'b0, skts_pkg::FUNC_INSERT, {64'd0, ALL_ONES});
      queue_op(1'b0, skts_pkg::FUNC_LOOKUP, {64'd5, 64'd5});
      queue_op(1'b0, skts_pkg::FUNC_LOOKUP, {64'd5, 64'd7});
      queue_op(1'b0, skts_pkg::FUNC_LOOKUP, {ALL_ONES, ALL_ONES}); // miss past the end
      queue_op(1'b0, skts_pkg::FUNC_LOOKUP, {64'd0, 64'd0});
      queue_op(1'b0, skts_pkg::FUNC_INSERT, {64'd0, 64'd0});
      queue_op(1'b0, skts_pkg::FUNC_INSERT,
               {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555});
      queue_op(1'b0, skts_pkg::FUNC_INSERT,
               {64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA});
      queue_op(1'b0, skts_pkg::FUNC_LOOKUP,
               {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555});
      issued.insert(issued.size(), {64'd5, 64'd5});
      issued.insert(issued.size(), {ALL_ONES, 64'd0});
      issued.insert(issued.size(), {64'd0, ALL_ONES});

      // random: fresh keys, repeats and near neighbors of earlier inserts,
      // and keys that share a hi word so the lo compare matters
      for (i = 0; i < RANDOM_OPS; i++) begin
         r = $urandom_range(99);
         if (r < 30) begin
            key = {$urandom, $urandom, $urandom, $urandom};
         end else if (r < 60) begin
            key = issued[$urandom_range(issued.size() - 1)];
         end else if (r < 80) begin
            key = issued[$urandom_range(issued.size() - 1)];
            key[WORD_W-1:0] = $urandom_range(1) ? key[WORD_W-1:0] + 1'b1
                                                : key[WORD_W-1:0] - 1'b1;
         end else begin
            case ($urandom_range(3))
               0: key[KEY_W-1:WORD_W] = '0;
               1: key[KEY_W-1:WORD_W] = ALL_ONES;
               2: key[KEY_W-1:WORD_W] = WORD_W'($urandom_range(3));
               default: key[KEY_W-1:WORD_W] =
                  issued[$urandom_range(issued.size() - 1)][KEY_W-1:WORD_W];
            endcase
            key[WORD_W-1:0] = {$urandom, $urandom};
         end
         func = ($urandom_range(99) < 55) ? skts_pkg::FUNC_INSERT : skts_pkg::FUNC_LOOKUP;
         // the all-ones key stays out so its lookup always misses past the end
         if (func == skts_pkg::FUNC_INSERT && key == {KEY_W{1'b1}}) key[0] = 1'b0;
         if (func == skts_pkg::FUNC_INSERT) issued.insert(issued.size(), key);
         queue_op(i == RANDOM_OPS / 2, func, key);
      end

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      wait (pending_ops.size() == 0 && !req_tvalid);
      wait (expected_results.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #200_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
